// ----- design/interval_table_check_and_match_assert.svh -----
// Assertion macros used by the interval table top level
`ifndef INTERVAL_TABLE_CHECK_AND_MATCH_ASSERT_SVH
`define INTERVAL_TABLE_CHECK_AND_MATCH_ASSERT_SVH

// same-cycle implication
`define ITCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/itcm_pkg.sv -----
// Types, constants and helpers for the interval table
`timescale 1ns / 1ps
`default_nettype none

package itcm_pkg;

  localparam int MAX_RANGES = 16;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_ORDER    = 3'd2;
  localparam logic [2:0] ST_OVERLAP  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] range_start;
    logic signed [31:0] range_end;
    logic signed [31:0] probe_value;
  } in_t;

  typedef struct packed {
    logic [2:0] table_status;
    logic       inside_hit;
    logic [4:0] range_count;
  } out_t;

  typedef struct packed {
    logic               vld;
    logic [1:0]         kind;
    logic signed [31:0] rs;
    logic signed [31:0] re;
    logic signed [31:0] pv;
    logic               hit;
    logic               ovl;
  } tok_t;

  function automatic logic [2:0] status_of(input logic order_f, input logic ovl_f,
                                           input logic ovf_f, input logic empty);
    logic [2:0] st;
    priority if (order_f) st = ST_ORDER;
    else if (ovl_f)       st = ST_OVERLAP;
    else if (ovf_f)       st = ST_OVERFLOW;
    else if (empty)       st = ST_EMPTY;
    else                  st = ST_OK;
    return st;
  endfunction

endpackage

`default_nettype wire

// ----- design/interval_table_check_and_match.sv -----
// Top level of the interval table: cell chain, fault flags and result register
//
//  channel | ports                          | carries
//  in      | in_valid  in_ready  in_data    | clear, add range or query word
//  out     | out_valid out_ready out_data   | status, hit bit and range count
//
//  An accepted word walks the chain one cell per cycle, 16 cells (MAX_RANGES).
//  The result is registered in the output register after the last cell, unless a held result stalls it.
//  One word is in flight at a time: the next word is accepted only after the result is registered.
//  Reset is synchronous; it empties the table and clears all fault flags.
//  A held result stalls the chain at its end; input stays blocked meanwhile.
`timescale 1ns / 1ps
`default_nettype none

`include "interval_table_check_and_match_assert.svh"

module interval_table_check_and_match (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire itcm_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output itcm_pkg::out_t     out_data
);

  localparam int M = itcm_pkg::MAX_RANGES;
  localparam int W = itcm_pkg::CNT_W;

  itcm_pkg::tok_t chain [0:M];
  logic [M-1:0]   stage_vld;

  logic                 busy_r;
  logic [W-1:0]         count_r;
  logic                 order_r;
  logic                 ovl_r;
  logic                 ovf_r;
  logic                 out_valid_r;
  itcm_pkg::out_t       out_r;

  logic [W-1:0]         count_nxt;
  logic                 order_nxt;
  logic                 ovl_nxt;
  logic                 ovf_nxt;
  itcm_pkg::out_t       out_nxt;
  logic [W+4:0]         count_ext;
  logic                 adv;
  logic                 fin;
  logic                 accept;
  itcm_pkg::tok_t       last;

  assign in_ready  = !busy_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    chain[0].vld  = accept;
    chain[0].kind = in_data.req_type;
    chain[0].rs   = in_data.range_start;
    chain[0].re   = in_data.range_end;
    chain[0].pv   = in_data.probe_value;
    chain[0].hit  = 1'b0;
    chain[0].ovl  = 1'b0;
  end

  assign last = chain[M];
  assign adv  = !(last.vld && out_valid_r && !out_ready);
  assign fin  = last.vld && adv;

  for (genvar i = 0; i < M; i++) begin : g_cell
    itcm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (W'(i)),
      .count    (count_r),
      .tok_i    (chain[i]),
      .tok_o    (chain[i+1])
    );
    assign stage_vld[i] = chain[i+1].vld;
  end

  always_comb begin
    count_nxt = count_r;
    order_nxt = order_r;
    ovl_nxt   = ovl_r;
    ovf_nxt   = ovf_r;
    unique case (last.kind)
      itcm_pkg::REQ_CLEAR: begin
        count_nxt = '0;
        order_nxt = 1'b0;
        ovl_nxt   = 1'b0;
        ovf_nxt   = 1'b0;
      end
      itcm_pkg::REQ_ADD: begin
        if (count_r == W'(M)) begin
          ovf_nxt = 1'b1;
        end else begin
          order_nxt = order_r | (last.rs >= last.re);
          ovl_nxt   = ovl_r | last.ovl;
          count_nxt = count_r + W'(1);
        end
      end
      default: begin
      end
    endcase
    count_ext            = {5'd0, count_nxt};
    out_nxt.table_status = itcm_pkg::status_of(order_nxt, ovl_nxt, ovf_nxt,
                                               count_nxt == '0);
    out_nxt.inside_hit   = (last.kind == itcm_pkg::REQ_QUERY) && last.hit;
    out_nxt.range_count  = count_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      order_r     <= 1'b0;
      ovl_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
      if (fin) begin
        count_r     <= count_nxt;
        order_r     <= order_nxt;
        ovl_r       <= ovl_nxt;
        ovf_r       <= ovf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_r <= out_nxt;
    end
  end

  `ITCM_ASSERT_NOW(a_count_bound, 1'b1, count_r <= W'(M), "range count beyond table size")
  `ITCM_ASSERT_NOW(a_one_word, 1'b1, $countones(stage_vld) <= 1, "more than one word in chain")
  `ITCM_ASSERT_NOW(a_idle_chain, in_ready, stage_vld == '0, "input open while chain busy")
  `ITCM_ASSERT_NEXT(a_clear_empties, fin && (last.kind == itcm_pkg::REQ_CLEAR),
                    count_r == '0 && out_valid_r, "clear left ranges in table")

endmodule

`default_nettype wire

// ----- design/itcm_cell.sv -----
// One table slot: holds a range, checks the passing word against it, hands it on
`timescale 1ns / 1ps
`default_nettype none

module itcm_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic [itcm_pkg::CNT_W-1:0] cell_idx,
  input  wire logic [itcm_pkg::CNT_W-1:0] count,
  input  wire itcm_pkg::tok_t           tok_i,
  output itcm_pkg::tok_t                tok_o
);

  logic               tok_vld_r;
  itcm_pkg::tok_t     tok_r;
  itcm_pkg::tok_t     tok_nxt;
  logic signed [31:0] start_r;
  logic signed [31:0] end_r;
  logic               active;
  logic               cut;
  logic               covers;
  logic               wr_en;

  always_comb begin
    active = cell_idx < count;
    cut    = ((tok_i.rs < start_r) && (start_r < tok_i.re)) ||
             ((tok_i.rs < end_r) && (end_r < tok_i.re)) ||
             ((start_r < tok_i.rs) && (tok_i.rs < end_r)) ||
             ((start_r < tok_i.re) && (tok_i.re < end_r));
    covers = (start_r <= tok_i.pv) && (tok_i.pv <= end_r);
    tok_nxt     = tok_i;
    tok_nxt.ovl = tok_i.ovl | (active && (tok_i.kind == itcm_pkg::REQ_ADD) && cut);
    tok_nxt.hit = tok_i.hit | (active && (tok_i.kind == itcm_pkg::REQ_QUERY) && covers);
    wr_en  = adv && tok_i.vld && (tok_i.kind == itcm_pkg::REQ_ADD) && (cell_idx == count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else if (adv) begin
      tok_vld_r <= tok_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
    if (wr_en) begin
      start_r <= tok_i.rs;
      end_r   <= tok_i.re;
    end
  end

  always_comb begin
    tok_o     = tok_r;
    tok_o.vld = tok_vld_r;
  end

endmodule

`default_nettype wire

// ----- dv/itcm_checker.sv -----
// Checker for the interval table: predicts each result and compares it field by field
`timescale 1ns / 1ps

module itcm_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  itcm_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  itcm_pkg::out_t out_data,
  output int             fail_count,
  output int             outstanding,
  output int             checked
);

  import itcm_pkg::*;

  logic signed [31:0] lo_tab [MAX_RANGES];
  logic signed [31:0] hi_tab [MAX_RANGES];
  int                 n_ranges;
  bit                 f_order;
  bit                 f_ovl;
  bit                 f_ovf;
  out_t               status_q [$];

  function automatic bit cuts_into(logic signed [31:0] a_lo, logic signed [31:0] a_hi,
                                   logic signed [31:0] b_lo, logic signed [31:0] b_hi);
    return (a_lo < b_lo && b_lo < a_hi) || (a_lo < b_hi && b_hi < a_hi);
  endfunction

  function automatic out_t apply_request(in_t w);
    out_t               r;
    logic signed [31:0] s;
    logic signed [31:0] e;
    logic signed [31:0] v;
    bit                 hit;
    s   = w.range_start;
    e   = w.range_end;
    v   = w.probe_value;
    hit = 1'b0;
    case (w.req_type)
      REQ_CLEAR: begin
        n_ranges = 0;
        f_order  = 1'b0;
        f_ovl    = 1'b0;
        f_ovf    = 1'b0;
      end
      REQ_ADD: begin
        if (n_ranges >= MAX_RANGES) begin
          f_ovf = 1'b1;
        end else begin
          if (s >= e) f_order = 1'b1;
          for (int i = 0; i < n_ranges; i++) begin
            if (cuts_into(s, e, lo_tab[i], hi_tab[i]) || cuts_into(lo_tab[i], hi_tab[i], s, e))
              f_ovl = 1'b1;
          end
          lo_tab[n_ranges] = s;
          hi_tab[n_ranges] = e;
          n_ranges++;
        end
      end
      REQ_QUERY: begin
        for (int i = 0; i < n_ranges; i++) begin
          if (lo_tab[i] <= v && v <= hi_tab[i]) hit = 1'b1;
        end
      end
      default: ;
    endcase
    if (f_order)            r.table_status = ST_ORDER;
    else if (f_ovl)         r.table_status = ST_OVERLAP;
    else if (f_ovf)         r.table_status = ST_OVERFLOW;
    else if (n_ranges == 0) r.table_status = ST_EMPTY;
    else                    r.table_status = ST_OK;
    r.inside_hit  = hit;
    r.range_count = 5'(n_ranges);
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      n_ranges   = 0;
      f_order    = 1'b0;
      f_ovl      = 1'b0;
      f_ovf      = 1'b0;
      fail_count = 0;
      checked    = 0;
      status_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
        end else begin
          want = status_q.pop_front();
          checked++;
          if (out_data.table_status !== want.table_status) begin
            fail_count++;
            $display("%0t: table_status mismatch, expected %0d, actual %0d", $time,
                     want.table_status, out_data.table_status);
          end
          if (out_data.inside_hit !== want.inside_hit) begin
            fail_count++;
            $display("%0t: inside_hit mismatch, expected %0d, actual %0d", $time,
                     want.inside_hit, out_data.inside_hit);
          end
          if (out_data.range_count !== want.range_count) begin
            fail_count++;
            $display("%0t: range_count mismatch, expected %0d, actual %0d", $time,
                     want.range_count, out_data.range_count);
          end
        end
      end
      if (in_valid && in_ready) status_q = {status_q, apply_request(in_data)};
    end
    outstanding = status_q.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the interval table: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_top;

  import itcm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int N_WORDS     = 1600;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int fail_count;
  int outstanding;
  int checked;
  int sent = 0;
  int quiet = 0;
  int last_drain = 0;
  bit held = 1'b0;
  bit small_mode;
  longint placed_lo [$];
  longint placed_hi [$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  interval_table_check_and_match i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  itcm_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet);
      $display("Test completed with failures");
      $finish;
    end
  end

  // hold off once for a long stretch, then run calm, else stall at random
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sent >= 300) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (sent >= 900 && sent < 1200) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 13);
      end
    end
  end

  function automatic in_t word(logic [1:0] kind, logic signed [31:0] s,
                               logic signed [31:0] e, logic signed [31:0] v);
    in_t w;
    w.req_type    = kind;
    w.range_start = s;
    w.range_end   = e;
    w.probe_value = v;
    return w;
  endfunction

  task automatic send(in_t w);
    if (!(sent >= 600 && sent < 900) && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic directed();
    send(word(REQ_QUERY, $urandom, $urandom, 0));
    send(word(REQ_UNUSED, $urandom, $urandom, $urandom));
    send(word(REQ_ADD, -10, 10, $urandom));
    send(word(REQ_QUERY, $urandom, $urandom, -10));
    send(word(REQ_QUERY, $urandom, $urandom, 10));
    send(word(REQ_QUERY, $urandom, $urandom, 11));
    send(word(REQ_ADD, 10, 20, $urandom));
    send(word(REQ_ADD, 10, 20, $urandom));
    send(word(REQ_ADD, 5, 5, $urandom));
    send(word(REQ_CLEAR, $urandom, $urandom, $urandom));
    send(word(REQ_ADD, VAL_MIN, VAL_MAX, $urandom));
    send(word(REQ_QUERY, $urandom, $urandom, VAL_MIN));
    send(word(REQ_QUERY, $urandom, $urandom, VAL_MAX));
    send(word(REQ_ADD, 0, 5, $urandom));
    send(word(REQ_CLEAR, $urandom, $urandom, $urandom));
    send(word(REQ_ADD, 0, -1, $urandom));
    send(word(REQ_ADD, -5, 3, $urandom));
    send(word(REQ_UNUSED, $urandom, $urandom, $urandom));
    send(word(REQ_CLEAR, VAL_MAX, VAL_MIN, VAL_MIN));
    for (int i = 0; i < MAX_RANGES; i++) send(word(REQ_ADD, 3 * i, 3 * i + 1, $urandom));
    send(word(REQ_ADD, 100, 200, $urandom));
    send(word(REQ_QUERY, $urandom, $urandom, 3 * (MAX_RANGES - 1) + 1));
    send(word(REQ_CLEAR, $urandom, $urandom, $urandom));
  endtask

  task automatic probe_table();
    logic signed [31:0] v;
    int p;
    if (placed_lo.size() > 0 && $urandom_range(0, 3) != 0) begin
      p = $urandom_range(0, placed_lo.size() - 1);
      v = 32'($urandom_range(0, 1) ? placed_lo[p] : placed_hi[p]);
      v = v + $signed($urandom_range(0, 2)) - 1;
    end else if (small_mode) begin
      v = $signed($urandom_range(0, 256)) - 128;
    end else begin
      v = $urandom;
    end
    send(word(REQ_QUERY, $urandom, $urandom, v));
  endtask

  // clear, add disjoint, touching, reversed or overlapping ranges, queries, may overfill
  task automatic fill_table();
    int slot [16];
    int n;
    int j;
    int tmp;
    int p;
    longint lo;
    longint hi;
    longint base;
    longint cur;
    send(word(REQ_CLEAR, $urandom, $urandom, $urandom));
    placed_lo.delete();
    placed_hi.delete();
    small_mode = ($urandom_range(0, 2) == 0);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_RANGES, MAX_RANGES + 3)
                                    : $urandom_range(1, MAX_RANGES - 1);
    for (int i = 0; i < 16; i++) slot[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = slot[i];
      slot[i] = slot[j];
      slot[j] = tmp;
    end
    cur = longint'($urandom_range(0, 200)) - 100;
    for (int k = 0; k < n; k++) begin
      if (small_mode) begin
        lo  = cur + $urandom_range(0, 2);
        hi  = lo + $urandom_range(1, 6);
        cur = hi;
      end else begin
        base = -64'sd2147483648 + longint'(slot[k % 16]) * (64'sd1 << 28);
        lo   = base + $urandom_range(0, 134217727);
        hi   = lo + 1 + $urandom_range(0, 134217726);
      end
      case ($urandom_range(0, 9))
        0: begin
          tmp = 0;
          base = lo;
          lo = hi;
          hi = ($urandom_range(0, 1)) ? base : lo;
        end
        1: begin
          if (placed_lo.size() > 0) begin
            p  = $urandom_range(0, placed_lo.size() - 1);
            lo = placed_lo[p] + 1;
            hi = placed_hi[p] + 1;
          end
        end
        default: ;
      endcase
      send(word(REQ_ADD, 32'(lo), 32'(hi), $urandom));
      placed_lo = {placed_lo, lo};
      placed_hi = {placed_hi, hi};
      if ($urandom_range(0, 1)) probe_table();
    end
    repeat ($urandom_range(1, 3)) probe_table();
  endtask

  task automatic send_noise();
    logic [1:0] kind;
    kind = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1))
      send(word(kind, $signed($urandom_range(0, 64)) - 32, $signed($urandom_range(0, 64)) - 32,
                $signed($urandom_range(0, 64)) - 32));
    else
      send(word(kind, $urandom, $urandom, $urandom));
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed();
    drain();
    last_drain = sent;
    while (sent < N_WORDS) begin
      if ($urandom_range(0, 9) < 7) fill_table();
      else repeat (8) send_noise();
      if (sent - last_drain >= 400) begin
        drain();
        last_drain = sent;
      end
    end
    drain();
    repeat (40) @(negedge clk);
    $display("%0d words sent, %0d results checked", sent, checked);
    $display("covered: edge ranges, touching and identical adds, fills past full, noise, stalls");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
